// ----- src/ipsp_pkg.sv -----
// ----------------------------------------------------------------------------
// ipsp_pkg - shared types and constants for the patch record parser
// Result kinds, the signature and end-mark constants, and the result word.
// ----------------------------------------------------------------------------
package ipsp_pkg;

  localparam int unsigned AddrW  = 24;
  localparam int unsigned SizeW  = 16;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned SigLen = 5;

  // "EOF" as a 3-byte big-endian offset ends the patch
  localparam logic [AddrW-1:0] END_MARK = 24'h454F46;

  typedef enum logic [2:0] {
    KIND_LITERAL = 3'd0,
    KIND_FILL    = 3'd1,
    KIND_END_OK  = 3'd2,
    KIND_BAD_HDR = 3'd3,
    KIND_TRUNC   = 3'd4
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [AddrW-1:0]  target_address;
    logic [SizeW-1:0]  run_length;
    logic [ByteW-1:0]  byte_value;
    logic              last;
  } result_t;

  // expected byte of the "PATCH" signature at a given position
  function automatic logic [ByteW-1:0] sig_byte(input logic [2:0] idx);
    logic [ByteW-1:0] b;
    case (idx)
      3'd0:    b = 8'h50;  // P
      3'd1:    b = 8'h41;  // A
      3'd2:    b = 8'h54;  // T
      3'd3:    b = 8'h43;  // C
      3'd4:    b = 8'h48;  // H
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// ----- src/ips_patch_record_parser.sv -----
// ----------------------------------------------------------------------------
// ips_patch_record_parser - byte-stream parser for IPS patch files
// Checks the signature, splits records into literal writes and fill runs.
// ----------------------------------------------------------------------------
// Usage:
//   Feed the patch file one byte per word on the in_ channel; raise in_tlast
//   on the final byte. Each word may produce zero, one or two result words on
//   the out_ channel: literal byte writes (one per data byte), fill runs (on
//   the fill byte), end record ok, bad header (on the fifth signature byte)
//   and truncated (when in_tlast comes before a complete end record and no
//   error was reported). out_tlast marks the last result caused by one input
//   word. Bytes after an end record or an error are dropped until in_tlast,
//   which rearms the parser to expect a new signature.
// Timing:
//   Results are registered into the result queue, whose entry 0 drives out_.
//   With the receiver always ready the block takes one byte every cycle, but
//   a byte that yields two results holds off the next byte, as the three-entry
//   result queue must have room for two words before a byte is taken.
// Reset and stalls:
//   rst_n (synchronous, active low) empties the queue and returns the parser
//   to the signature check. When out_tready is low the queue fills and
//   in_tready drops once fewer than two entries are free; nothing is lost.
// ----------------------------------------------------------------------------
module ips_patch_record_parser
  import ipsp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,   // stream_end
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [23:0] target_address, [39:24] run_length,
                                  // [47:40] byte_value
  output logic [2:0]  out_tuser,  // [2:0] kind
  output logic        out_tlast   // last
);

  typedef enum logic [2:0] {
    PH_HDR_GOOD,
    PH_HDR_BAD,
    PH_OFFSET,
    PH_SIZE,
    PH_LITERAL,
    PH_RUNLEN,
    PH_FILLVAL,
    PH_IDLE
  } phase_t;

  localparam int unsigned QDepth = 3;

  // parser state
  phase_t            phase_r,  phase_nxt;
  logic [2:0]        fidx_r,   fidx_nxt;
  logic [AddrW-1:0]  offset_r, offset_nxt;
  logic [SizeW-1:0]  size_r,   size_nxt;
  logic [SizeW-1:0]  done_r,   done_nxt;

  // result queue; entry 0 drives the out_ port
  result_t           q_r [QDepth];
  result_t           q_nxt [QDepth];
  logic [1:0]        cnt_r, cnt_nxt;

  logic              in_fire, pop;
  logic [ByteW-1:0]  b;
  result_t           res0, res1;
  logic [1:0]        nres;
  logic [1:0]        cnt_pop;
  logic [2:0]        fidx_inc;
  logic              hdr_bad;
  logic [AddrW-1:0]  off_shift;
  logic [SizeW-1:0]  size_shift;
  logic [SizeW-1:0]  done_inc;
  result_t           r;
  result_t           zero_res;

  assign in_fire    = in_tvalid && in_tready;
  assign in_tready  = (cnt_r <= 2'd1);
  assign out_tvalid = (cnt_r != 2'd0);
  assign pop        = out_tvalid && out_tready;
  assign b          = in_tdata;

  assign out_tdata = {q_r[0].byte_value, q_r[0].run_length, q_r[0].target_address};
  assign out_tuser = q_r[0].kind;
  assign out_tlast = q_r[0].last;

  assign fidx_inc   = fidx_r + 3'd1;
  assign off_shift  = {offset_r[AddrW-ByteW-1:0], b};
  assign size_shift = {size_r[SizeW-ByteW-1:0], b};
  assign done_inc   = done_r + 16'd1;
  assign hdr_bad    = (phase_r == PH_HDR_BAD) || (b != sig_byte(fidx_r));

  // parse one byte: next state and up to two results
  always_comb begin
    zero_res   = '{kind: KIND_LITERAL, target_address: '0, run_length: '0,
                   byte_value: '0, last: 1'b0};
    phase_nxt  = phase_r;
    fidx_nxt   = fidx_r;
    offset_nxt = offset_r;
    size_nxt   = size_r;
    done_nxt   = done_r;
    res0       = zero_res;
    res1       = zero_res;
    nres       = 2'd0;
    r          = zero_res;

    case (phase_r)
      PH_HDR_GOOD, PH_HDR_BAD: begin
        phase_nxt = hdr_bad ? PH_HDR_BAD : PH_HDR_GOOD;
        fidx_nxt  = fidx_inc;
        if (fidx_inc >= 3'(SigLen)) begin
          fidx_nxt = 3'd0;
          if (hdr_bad) begin
            r.kind    = KIND_BAD_HDR;
            res0      = r;
            nres      = 2'd1;
            phase_nxt = PH_IDLE;
          end else begin
            phase_nxt = PH_OFFSET;
          end
        end
      end
      PH_OFFSET: begin
        offset_nxt = off_shift;
        fidx_nxt   = fidx_inc;
        if (fidx_inc >= 3'd3) begin
          fidx_nxt = 3'd0;
          if (off_shift == END_MARK) begin
            r.kind    = KIND_END_OK;
            res0      = r;
            nres      = 2'd1;
            phase_nxt = PH_IDLE;
          end else begin
            size_nxt  = '0;
            phase_nxt = PH_SIZE;
          end
        end
      end
      PH_SIZE: begin
        size_nxt = size_shift;
        fidx_nxt = fidx_inc;
        if (fidx_inc >= 3'd2) begin
          fidx_nxt  = 3'd0;
          done_nxt  = '0;
          phase_nxt = (size_shift != '0) ? PH_LITERAL : PH_RUNLEN;
        end
      end
      PH_LITERAL: begin
        // address wraps modulo 2^24
        r.kind           = KIND_LITERAL;
        r.target_address = offset_r + {{(AddrW-SizeW){1'b0}}, done_r};
        r.byte_value     = b;
        res0             = r;
        nres             = 2'd1;
        done_nxt         = done_inc;
        if (done_inc == size_r) begin
          phase_nxt = PH_OFFSET;
        end
      end
      PH_RUNLEN: begin
        size_nxt = size_shift;
        fidx_nxt = fidx_inc;
        if (fidx_inc >= 3'd2) begin
          fidx_nxt  = 3'd0;
          phase_nxt = PH_FILLVAL;
        end
      end
      PH_FILLVAL: begin
        r.kind           = KIND_FILL;
        r.target_address = offset_r;
        r.run_length     = size_r;
        r.byte_value     = b;
        res0             = r;
        nres             = 2'd1;
        phase_nxt        = PH_OFFSET;
      end
      default: begin
        // idle: drop trailing bytes
      end
    endcase

    // end of stream: report truncation, then rearm
    if (in_tlast) begin
      if (phase_nxt != PH_IDLE) begin
        r      = zero_res;
        r.kind = KIND_TRUNC;
        if (nres == 2'd0) begin
          res0 = r;
        end else begin
          res1 = r;
        end
        nres = nres + 2'd1;
      end
      phase_nxt  = PH_HDR_GOOD;
      fidx_nxt   = 3'd0;
      offset_nxt = '0;
      size_nxt   = '0;
      done_nxt   = '0;
    end

    if (nres == 2'd1) begin
      res0.last = 1'b1;
    end else if (nres == 2'd2) begin
      res1.last = 1'b1;
    end

    if (!in_fire) begin
      nres = 2'd0;
    end
  end

  // result queue: shift out on pop, append new results behind what remains
  assign cnt_pop = cnt_r - {1'b0, pop};

  always_comb begin
    for (int i = 0; i < QDepth; i++) begin
      if (pop) begin
        q_nxt[i] = (i < QDepth - 1) ? q_r[(i + 1) % QDepth] : q_r[i];
      end else begin
        q_nxt[i] = q_r[i];
      end
      if ((nres != 2'd0) && (i == int'(cnt_pop))) begin
        q_nxt[i] = res0;
      end
      if ((nres == 2'd2) && (i == int'(cnt_pop) + 1)) begin
        q_nxt[i] = res1;
      end
    end
    cnt_nxt = cnt_pop + nres;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HDR_GOOD;
      fidx_r   <= 3'd0;
      offset_r <= '0;
      size_r   <= '0;
      done_r   <= '0;
      cnt_r    <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (in_fire) begin
        phase_r  <= phase_nxt;
        fidx_r   <= fidx_nxt;
        offset_r <= offset_nxt;
        size_r   <= size_nxt;
        done_r   <= done_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < QDepth; i++) begin
      q_r[i] <= q_nxt[i];
    end
  end

`ifndef SYNTHESIS
  // end of stream always rearms the signature check
  a_rearm: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_tlast |=> (phase_r == PH_HDR_GOOD) && (fidx_r == 3'd0))
    else $error("parser not rearmed after end of stream");

  // queue never overflows
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |-> ({1'b0, cnt_pop} + {1'b0, nres}) <= 3'(QDepth))
    else $error("result queue overflow");

  // end of stream outside idle always yields a result
  a_tlast_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_tlast && (phase_r != PH_IDLE) |-> nres != 2'd0)
    else $error("end of stream without a result");

  // field counter stays within its field
  a_fidx_range: assert property (@(posedge clk) disable iff (!rst_n)
    ((phase_r == PH_OFFSET) |-> (fidx_r <= 3'd2)) and
    ((phase_r == PH_HDR_GOOD || phase_r == PH_HDR_BAD) |-> (fidx_r <= 3'd4)))
    else $error("field index out of range");
`endif

endmodule

// ----- sim/ips_patch_record_parser_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ips_patch_record_parser_tb - self-checking bench for the patch record parser
// Streams patch files through the parser, one byte per word, under random
// gaps and stalls. A bench-side copy of the parse state predicts every result
// word, and each result that leaves the block is compared field by field.
// ----------------------------------------------------------------------------
module ips_patch_record_parser_tb;
  import ipsp_pkg::*;

  localparam int unsigned HALF_PERIOD  = 5;
  localparam int unsigned RESET_CYCLES = 6;
  localparam int unsigned RAND_BYTES   = 680;
  localparam int unsigned MAX_REPORTS  = 10;
  localparam int unsigned SETTLE_CYCLES = 20;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned RUN_LIMIT_NS = 5_000_000;
  localparam logic [39:0] SIGNATURE    = "PATCH";

  // parse position of the bench copy
  typedef enum logic [3:0] {
    PH_SIG_OK,
    PH_SIG_BAD,
    PH_OFFSET,
    PH_SIZE,
    PH_LITERAL,
    PH_RUNLEN,
    PH_FILLVAL,
    PH_IDLE
  } parse_phase_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        out_tlast;

  // parse state of the bench copy
  parse_phase_t     m_phase;
  logic [2:0]       m_field;
  logic [AddrW-1:0] m_offset;
  logic [SizeW-1:0] m_size;
  logic [SizeW-1:0] m_done;

  result_t    pending_results[$];  // predicted result words, oldest first
  logic [7:0] patch_bytes[$];      // patch file being assembled for sending
  int         fail_count = 0;
  int         bytes_sent = 0;
  int         hold_left  = 0;      // receiver hold-off, counted down per cycle
  bit         tx_idle    = 1'b1;
  bit         rx_idle    = 1'b1;

  ips_patch_record_parser u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    clk = 1'b0;
    #HALF_PERIOD;
    clk = 1'b1;
    #HALF_PERIOD;
  end

  // Gap length: mostly none, often a short one, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic clear_parse_state();
    m_phase  = PH_SIG_OK;
    m_field  = '0;
    m_offset = '0;
    m_size   = '0;
    m_done   = '0;
  endtask

  function automatic result_t make_result(kind_t k, logic [AddrW-1:0] addr,
                                          logic [SizeW-1:0] run, logic [7:0] val);
    result_t res;
    res.kind           = k;
    res.target_address = addr;
    res.run_length     = run;
    res.byte_value     = val;
    res.last           = 1'b0;
    return res;
  endfunction

  // Advance the parse state by one accepted byte and queue the result words
  // that the byte causes; the final one of them carries the last flag.
  task automatic predict_parser_results(input logic [7:0] b, input logic fin);
    result_t          step_q[$];
    logic [AddrW-1:0] lit_addr;
    case (m_phase)
      PH_SIG_OK, PH_SIG_BAD: begin
        if (b != SIGNATURE[39 - 8*m_field -: 8]) m_phase = PH_SIG_BAD;
        if (m_field == 3'd4) begin
          m_field = '0;
          if (m_phase == PH_SIG_BAD) begin
            step_q.push_back(make_result(KIND_BAD_HDR, '0, '0, '0));
            m_phase = PH_IDLE;
          end else begin
            m_phase = PH_OFFSET;
          end
        end else begin
          m_field++;
        end
      end
      PH_OFFSET: begin
        m_offset = {m_offset[15:0], b};
        if (m_field == 3'd2) begin
          m_field = '0;
          if (m_offset == END_MARK) begin
            step_q.push_back(make_result(KIND_END_OK, '0, '0, '0));
            m_phase = PH_IDLE;
          end else begin
            m_size  = '0;
            m_phase = PH_SIZE;
          end
        end else begin
          m_field++;
        end
      end
      PH_SIZE: begin
        m_size = {m_size[7:0], b};
        if (m_field == 3'd1) begin
          m_field = '0;
          m_done  = '0;
          if (m_size != '0) m_phase = PH_LITERAL;
          else m_phase = PH_RUNLEN;
        end else begin
          m_field++;
        end
      end
      PH_LITERAL: begin
        lit_addr = m_offset + m_done;  // wraps at 24 bits
        step_q.push_back(make_result(KIND_LITERAL, lit_addr, '0, b));
        m_done++;
        if (m_done == m_size) m_phase = PH_OFFSET;
      end
      PH_RUNLEN: begin
        m_size = {m_size[7:0], b};
        if (m_field == 3'd1) begin
          m_field = '0;
          m_phase = PH_FILLVAL;
        end else begin
          m_field++;
        end
      end
      PH_FILLVAL: begin
        step_q.push_back(make_result(KIND_FILL, m_offset, m_size, b));
        m_phase = PH_OFFSET;
      end
      default: ;
    endcase
    // end of stream before a clean end record reports truncation, then rearm
    if (fin) begin
      if (m_phase != PH_IDLE) step_q.push_back(make_result(KIND_TRUNC, '0, '0, '0));
      clear_parse_state();
    end
    if (step_q.size() != 0) step_q[step_q.size()-1].last = 1'b1;
    foreach (step_q[i]) pending_results.push_back(step_q[i]);
  endtask

  // Offer one word and hold it until the block takes it. Entered and left
  // at a falling edge; tvalid stays high for a following word with no gap.
  task automatic send_byte(input logic [7:0] b, input logic fin);
    int gap;
    gap = tx_idle ? pick_gap() : 0;
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= fin;
    do @(posedge clk); while (!in_tready);
    predict_parser_results(b, fin);
    bytes_sent++;
    @(negedge clk);
  endtask

  // Send the assembled file, marking its final byte as the stream end.
  task automatic send_patch();
    foreach (patch_bytes[i]) send_byte(patch_bytes[i], i == patch_bytes.size() - 1);
    patch_bytes.delete();
  endtask

  // Hold the sender until every predicted word has come out, then settle.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic void add_field(input logic [23:0] v, input int nbytes);
    for (int i = nbytes - 1; i >= 0; i--) patch_bytes.push_back(v[8*i +: 8]);
  endfunction

  function automatic void add_signature();
    for (int i = 0; i < SigLen; i++) patch_bytes.push_back(SIGNATURE[39 - 8*i -: 8]);
  endfunction

  // Mostly well-formed files with random records; some get a damaged
  // signature, some are cut short, a few are plain noise.
  function automatic void build_random_patch();
    int               r;
    int               nrec;
    int               keep;
    int               idx;
    logic [AddrW-1:0] offset;
    logic [SizeW-1:0] len;
    r = $urandom_range(0, 99);
    if (r < 5) begin
      repeat ($urandom_range(1, 12)) patch_bytes.push_back(8'($urandom));
      return;
    end
    add_signature();
    if (r < 15) begin
      idx = $urandom_range(0, SigLen - 1);
      patch_bytes[idx] = patch_bytes[idx] ^ 8'($urandom_range(1, 255));
    end
    nrec = $urandom_range(0, 5);
    repeat (nrec) begin
      offset = 24'($urandom);
      if ($urandom_range(0, 7) == 0) offset = 24'hFFFFFF - 24'($urandom_range(0, 3));
      if (offset == END_MARK) offset = offset ^ 24'h1;
      add_field(offset, 3);
      if ($urandom_range(0, 2) == 0) begin
        add_field(24'h0, 2);
        case ($urandom_range(0, 5))
          0:       len = 16'h0000;
          1:       len = 16'hFFFF;
          default: len = 16'($urandom);
        endcase
        add_field(24'(len), 2);
        patch_bytes.push_back(8'($urandom));
      end else begin
        if ($urandom_range(0, 15) == 0) len = 16'($urandom_range(20, 48));
        else len = 16'($urandom_range(1, 6));
        add_field(24'(len), 2);
        repeat (len) patch_bytes.push_back(8'($urandom));
      end
    end
    add_field(END_MARK, 3);
    if ($urandom_range(0, 1) == 0) begin
      repeat ($urandom_range(1, 3)) patch_bytes.push_back(8'($urandom));
    end
    if (r >= 15 && r < 30) begin
      keep = $urandom_range(1, patch_bytes.size());
      while (patch_bytes.size() > keep) void'(patch_bytes.pop_back());
    end
  endfunction

  task automatic run_random_patches(input int nbytes);
    int target;
    target = bytes_sent + nbytes;
    while (bytes_sent < target) begin
      build_random_patch();
      send_patch();
    end
  endtask

  // --------------------------------------------------------------------------
  // Test tasks
  // --------------------------------------------------------------------------

  // Literal record at the top of the address space (wraps to zero), a fill
  // of full run length, and a clean end record on the final byte.
  task automatic test_clean_patch();
    add_signature();
    add_field(24'hFFFFFF, 3);
    add_field(24'h0002, 2);
    patch_bytes.push_back(8'hA5);
    patch_bytes.push_back(8'h5A);
    add_field(24'h123456, 3);
    add_field(24'h0000, 2);
    add_field(24'hFFFF, 2);
    patch_bytes.push_back(8'hFF);
    add_field(END_MARK, 3);
    send_patch();
    drain_results();
  endtask

  // Wrong first signature byte; the trailing byte after the error is dropped.
  task automatic test_bad_header();
    add_signature();
    patch_bytes[0] = 8'h00;
    patch_bytes.push_back(8'h45);
    send_patch();
    drain_results();
  endtask

  // Stream ending inside the signature, and on the byte that completes a
  // fill record of zero run length (fill result first, truncation second).
  task automatic test_early_end();
    patch_bytes.push_back(8'h50);
    send_patch();
    add_signature();
    add_field(24'h000010, 3);
    add_field(24'h0000, 2);
    add_field(24'h0000, 2);
    patch_bytes.push_back(8'h00);
    send_patch();
    drain_results();
  endtask

  task automatic test_random_traffic();
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    run_random_patches(RAND_BYTES / 2);
    drain_results();
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    run_random_patches(RAND_BYTES / 6);
    drain_results();
    tx_idle = 1'b1;
    run_random_patches(RAND_BYTES / 6);
    tx_idle = 1'b0;
    rx_idle = 1'b1;
    run_random_patches(RAND_BYTES / 6);
    drain_results();
  endtask

  // Freeze the receiver while the sender streams a long literal record back
  // to back, so the result queue fills and the input stalls.
  task automatic test_output_holdoff();
    tx_idle   = 1'b0;
    rx_idle   = 1'b0;
    hold_left = HOLD_CYCLES;
    add_signature();
    add_field(24'hABCDEF, 3);
    add_field(24'd40, 2);
    repeat (40) patch_bytes.push_back(8'($urandom));
    add_field(END_MARK, 3);
    send_patch();
    drain_results();
    tx_idle = 1'b1;
    rx_idle = 1'b1;
  endtask

  // --------------------------------------------------------------------------
  // Receiver: drive out_tready at the falling edge. A requested hold-off
  // wins; otherwise stall at random when enabled, else stay ready.
  // --------------------------------------------------------------------------
  initial begin
    int stall;
    stall      = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left != 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else if (rx_idle && stall != 0) begin
        out_tready <= 1'b0;
        stall--;
      end else begin
        out_tready <= 1'b1;
        if (rx_idle && $urandom_range(0, 3) == 0) stall = pick_gap();
      end
    end
  end

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS) $display("%0t: %s", $realtime, msg);
  endtask

  // --------------------------------------------------------------------------
  // Checker: take each accepted result word and compare it with the oldest
  // prediction. Sampled at the rising edge, before the block updates.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        note_failure($sformatf("unexpected word: kind %0d addr %06h run %04h val %02h last %0b",
                               out_tuser, out_tdata[23:0], out_tdata[39:24],
                               out_tdata[47:40], out_tlast));
      end else begin
        want = pending_results.pop_front();
        if (out_tuser != want.kind || out_tdata[23:0] != want.target_address ||
            out_tdata[39:24] != want.run_length || out_tdata[47:40] != want.byte_value ||
            out_tlast != want.last) begin
          note_failure($sformatf({"mismatch: expected kind %0d addr %06h run %04h val %02h",
                                  " last %0b, got kind %0d addr %06h run %04h val %02h",
                                  " last %0b"},
                                 want.kind, want.target_address, want.run_length,
                                 want.byte_value, want.last, out_tuser, out_tdata[23:0],
                                 out_tdata[39:24], out_tdata[47:40], out_tlast));
        end
      end
    end
  end

  // Main sequence: reset once, then run each test in turn.
  initial begin
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tlast  = 1'b0;
    rst_n     = 1'b0;
    clear_parse_state();
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_clean_patch();
    test_bad_header();
    test_early_end();
    test_output_holdoff();
    test_random_traffic();

    drain_results();
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog: end the run if the block hangs or a result never shows.
  initial begin
    #RUN_LIMIT_NS;
    $display("Verification failed");
    $finish;
  end

endmodule

// ----- sim.f -----
src/ipsp_pkg.sv
src/ips_patch_record_parser.sv
sim/ips_patch_record_parser_tb.sv
